// ----- rtl/core/lfsa_pkg.sv -----
`timescale 1ns / 1ps

package lfsa_pkg;

   localparam int SEAT_COUNT = 64;

   localparam int TIME_W  = 20;
   localparam int SEAT_W  = 6;
   localparam int COUNT_W = 16;
   localparam int USED_W  = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_PICK  = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic pick;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

// ----- rtl/core/lfsa_datapath.sv -----
`timescale 1ns / 1ps

module lfsa_datapath #(
   parameter int SEAT_COUNT = lfsa_pkg::SEAT_COUNT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lfsa_pkg::cmd_type                  cmd,
   output lfsa_pkg::status_type               status,
   input  logic [lfsa_pkg::TIME_W-1:0]        req_start_time,
   input  logic [lfsa_pkg::TIME_W-1:0]        req_end_time,
   output logic [lfsa_pkg::SEAT_W-1:0]        rsp_seat_given,
   output logic [lfsa_pkg::COUNT_W-1:0]       rsp_seat_use_count,
   output logic [lfsa_pkg::USED_W-1:0]        rsp_seats_used,
   output logic                               rsp_no_seat
);

   localparam int IW     = $clog2(SEAT_COUNT);
   localparam int UW     = $clog2(SEAT_COUNT + 1);
   localparam int LEAVES = 1 << IW;

   logic [SEAT_COUNT-1:0]            busy_ff, busy_in, set_vec, rel_vec;
   logic [lfsa_pkg::TIME_W-1:0]      end_ff;
   logic [lfsa_pkg::TIME_W-1:0]      seat_end_ff [0:SEAT_COUNT-1];
   logic [IW-1:0]                    pick_ff, clr_ff, clr_in;
   logic                             found_ff;
   logic [lfsa_pkg::COUNT_W-1:0]     rd_ff, count_next;
   logic [lfsa_pkg::COUNT_W-1:0]     cnt_mem [0:SEAT_COUNT-1];
   logic [UW-1:0]                    high_ff, high_in, pick_plus;
   logic                             mem_we;
   logic [IW-1:0]                    mem_wa;
   logic [lfsa_pkg::COUNT_W-1:0]     mem_wd;
   logic                             tv [0:IW][0:LEAVES-1];
   logic [IW-1:0]                    ti [0:IW][0:LEAVES-1];
   logic [lfsa_pkg::SEAT_W-1:0]      given_ff;
   logic [lfsa_pkg::COUNT_W-1:0]     use_ff;
   logic [lfsa_pkg::USED_W-1:0]      used_ff;
   logic                             no_seat_ff;

   // Per-seat lanes: set on commit, release against the new start on transfer.
   for (genvar i = 0; i < SEAT_COUNT; i++) begin : g_lane
      logic [lfsa_pkg::TIME_W-1:0] cmp_end;
      assign set_vec[i] = cmd.commit && found_ff && (pick_ff == IW'(i));
      assign cmp_end    = set_vec[i] ? end_ff : seat_end_ff[i];
      assign rel_vec[i] = cmd.accept && (cmp_end < req_start_time);

      always_ff @(posedge clock) begin
         if (set_vec[i]) begin
            seat_end_ff[i] <= end_ff;
         end
      end
   end

   assign busy_in = (busy_ff | set_vec) & ~rel_vec;

   // Lowest free seat through a binary tree of pairwise picks.
   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < SEAT_COUNT) begin : g_real
         assign tv[0][j] = ~busy_ff[j];
      end else begin : g_pad
         assign tv[0][j] = 1'b0;
      end
      assign ti[0][j] = IW'(j);
   end

   for (genvar lv = 0; lv < IW; lv++) begin : g_level
      for (genvar j = 0; j < (LEAVES >> (lv + 1)); j++) begin : g_node
         assign tv[lv+1][j] = tv[lv][2*j] | tv[lv][2*j+1];
         assign ti[lv+1][j] = tv[lv][2*j] ? ti[lv][2*j] : ti[lv][2*j+1];
      end
   end

   assign count_next = (rd_ff == lfsa_pkg::COUNT_MAX) ? rd_ff : rd_ff + 1'b1;
   assign pick_plus  = UW'(pick_ff) + UW'(1);
   assign high_in    = (cmd.commit && found_ff && (pick_plus > high_ff)) ? pick_plus : high_ff;
   assign clr_in     = cmd.clear ? clr_ff + 1'b1 : clr_ff;

   assign status.clear_last = (clr_ff == IW'(SEAT_COUNT - 1));

   assign mem_we = cmd.clear || (cmd.commit && found_ff);
   assign mem_wa = cmd.clear ? clr_ff : pick_ff;
   assign mem_wd = cmd.clear ? '0 : count_next;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem[mem_wa] <= mem_wd;
      end
      if (cmd.pick) begin
         rd_ff <= cnt_mem[ti[IW][0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         high_ff <= '0;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         high_ff <= high_in;
         clr_ff  <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         end_ff <= req_end_time;
      end
      if (cmd.pick) begin
         found_ff <= tv[IW][0];
         pick_ff  <= ti[IW][0];
      end
      if (cmd.commit) begin
         given_ff   <= found_ff ? lfsa_pkg::SEAT_W'(pick_ff) : '0;
         use_ff     <= found_ff ? count_next : '0;
         used_ff    <= lfsa_pkg::USED_W'(high_in);
         no_seat_ff <= ~found_ff;
      end
   end

   assign rsp_seat_given     = given_ff;
   assign rsp_seat_use_count = use_ff;
   assign rsp_seats_used     = used_ff;
   assign rsp_no_seat        = no_seat_ff;

endmodule

// ----- rtl/core/lfsa_ctrl.sv -----
`timescale 1ns / 1ps

module lfsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  lfsa_pkg::status_type status,
   output lfsa_pkg::cmd_type    cmd
);

   lfsa_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == lfsa_pkg::ST_IDLE) ||
                      ((state_ff == lfsa_pkg::ST_WRITE) && out_free);

   assign cmd.clear  = (state_ff == lfsa_pkg::ST_CLEAR);
   assign cmd.accept = req_valid && req_ready;
   assign cmd.pick   = (state_ff == lfsa_pkg::ST_PICK);
   assign cmd.commit = (state_ff == lfsa_pkg::ST_WRITE) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfsa_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = lfsa_pkg::ST_IDLE;
            end
         end
         lfsa_pkg::ST_IDLE: begin
            if (cmd.accept) begin
               state_in = lfsa_pkg::ST_PICK;
            end
         end
         lfsa_pkg::ST_PICK: begin
            state_in = lfsa_pkg::ST_WRITE;
         end
         lfsa_pkg::ST_WRITE: begin
            if (out_free) begin
               state_in = cmd.accept ? lfsa_pkg::ST_PICK : lfsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfsa_pkg::ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfsa_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/lowest_free_seat_allocator.sv -----
`timescale 1ns / 1ps
// Each request goes through a pick state and then a write state, where the result
// is registered once the output is free; a new interval can be taken in that write
// state, and the pick and write steps share the use-count memory port.
// Reset: all seats free and the seat high mark cleared; the use-count memory
// is then cleared one seat per cycle, over all SEAT_COUNT seats, with req_ready low.
module lowest_free_seat_allocator #(
   parameter int SEAT_COUNT = lfsa_pkg::SEAT_COUNT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [lfsa_pkg::TIME_W-1:0]        req_start_time,
   input  logic [lfsa_pkg::TIME_W-1:0]        req_end_time,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lfsa_pkg::SEAT_W-1:0]        rsp_seat_given,
   output logic [lfsa_pkg::COUNT_W-1:0]       rsp_seat_use_count,
   output logic [lfsa_pkg::USED_W-1:0]        rsp_seats_used,
   output logic                               rsp_no_seat
);

   lfsa_pkg::cmd_type    cmd;
   lfsa_pkg::status_type status;

   lfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfsa_datapath #(
      .SEAT_COUNT (SEAT_COUNT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_start_time     (req_start_time),
      .req_end_time       (req_end_time),
      .rsp_seat_given     (rsp_seat_given),
      .rsp_seat_use_count (rsp_seat_use_count),
      .rsp_seats_used     (rsp_seats_used),
      .rsp_no_seat        (rsp_no_seat)
   );

   // A request transfer is always followed by a cycle without one.
   a_two_cycle_spacing: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken in consecutive cycles");

   // A refused interval carries no seat and no count.
   a_no_seat_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_seat) |-> (rsp_seat_given == '0 && rsp_seat_use_count == '0))
      else $error("refused interval carries seat data");

   // A granted seat has been used at least once, and the high mark covers it.
   a_grant_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_no_seat) |-> (rsp_seat_use_count != '0 && rsp_seats_used != '0))
      else $error("granted seat without count or high mark");

   // The clearing pass keeps the request side closed right after reset.
   a_closed_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request side open during clearing pass");

endmodule
